/* hdl/ttd_pkg.sv */
package ttd_pkg;

	// fixed field widths
	localparam int VALUE_W = 16;
	localparam int POS_W   = 12;

	// parameter defaults
	localparam int DEF_MAX_LEN    = 4096;
	localparam int DEF_VALUE_BITS = 16;

	// configuration port
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	// register index, taken from paddr[2]
	localparam logic REG_THRESHOLD = 1'b0;
	localparam logic REG_MODE      = 1'b1;

	// result queue
	localparam int RQ_DEPTH = 4;
	localparam int RQ_PTR_W = 2;
	localparam int RQ_CNT_W = 3;

	typedef struct packed {
		logic [POS_W-1:0] position;
		logic             has_position;
		logic             list_end;
	} res_t;

	// results produced by one item, handed to the result queue
	typedef struct packed {
		logic [1:0] count;
		res_t       first;
		res_t       second;
	} push_t;

endpackage

/* hdl/ttd_if.sv */
interface ttd_sample_if import ttd_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] value;
	logic               end_of_sequence;

	modport source (output valid, output value, output end_of_sequence, input ready);
	modport sink (input valid, input value, input end_of_sequence, output ready);
endinterface

interface ttd_result_if import ttd_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [POS_W-1:0] position;
	logic             has_position;
	logic             list_end;

	modport source (output valid, output position, output has_position, output list_end,
		input ready);
	modport sink (input valid, input position, input has_position, input list_end,
		output ready);
endinterface

/* hdl/ttd_track.sv */
module ttd_track import ttd_pkg::*; #(
	parameter int MAX_LEN    = DEF_MAX_LEN,
	parameter int VALUE_BITS = DEF_VALUE_BITS
) (
	input  logic                                                  clk,
	input  logic                                                  arst_n,
	input  logic                                                  fire,
	input  logic [VALUE_W-1:0]                                    value,
	input  logic                                                  eos,
	input  logic [((VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W)-1:0] threshold,
	input  logic                                                  mode,
	output push_t                                                 push
);

	localparam int VAL_W   = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
	localparam int CNT_W   = $clog2(MAX_LEN);
	localparam int POS_X_W = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_LEN - 1);

	logic [CNT_W-1:0] count_q;
	logic [VAL_W-1:0] best_val_q;
	logic [CNT_W-1:0] best_pos_q;
	logic [VAL_W-1:0] run_val_q;
	logic [CNT_W-1:0] run_pos_q;

	logic [VAL_W-1:0]   v;
	logic               trig;
	logic [VAL_W-1:0]   best_val_d;
	logic [CNT_W-1:0]   best_pos_d;
	logic [VAL_W-1:0]   run_val_d;
	logic [CNT_W-1:0]   run_pos_d;
	logic [POS_X_W-1:0] cur_pos_x;
	logic [POS_X_W-1:0] best_pos_x;
	logic [POS_X_W-1:0] run_pos_x;

	assign v    = value[VAL_W-1:0];
	assign trig = v > threshold;

	// strict compare against best, then runner
	always_comb begin
		best_val_d = best_val_q;
		best_pos_d = best_pos_q;
		run_val_d  = run_val_q;
		run_pos_d  = run_pos_q;
		if (v > best_val_q) begin
			run_val_d  = best_val_q;
			run_pos_d  = best_pos_q;
			best_val_d = v;
			best_pos_d = count_q;
		end else if (v > run_val_q) begin
			run_val_d = v;
			run_pos_d = count_q;
		end
	end

	assign cur_pos_x  = POS_X_W'(count_q);
	assign best_pos_x = POS_X_W'(best_pos_d);
	assign run_pos_x  = POS_X_W'(run_pos_d);

	always_comb begin
		push.count  = 2'd0;
		push.first  = '0;
		push.second = '0;
		push.second.position     = run_pos_x[POS_W-1:0];
		push.second.has_position = 1'b1;
		push.second.list_end     = 1'b1;
		if (mode) begin
			push.first.position     = best_pos_x[POS_W-1:0];
			push.first.has_position = 1'b1;
			push.first.list_end     = 1'b0;
			if (fire && eos) begin
				push.count = 2'd2;
			end
		end else begin
			// bare end marker when the last item does not trigger
			push.first.position     = trig ? cur_pos_x[POS_W-1:0] : '0;
			push.first.has_position = trig;
			push.first.list_end     = eos;
			if (fire && (trig || eos)) begin
				push.count = 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			best_val_q <= '0;
			best_pos_q <= '0;
			run_val_q  <= '0;
			run_pos_q  <= '0;
		end else if (fire) begin
			if (eos) begin
				count_q    <= '0;
				best_val_q <= '0;
				best_pos_q <= '0;
				run_val_q  <= '0;
				run_pos_q  <= '0;
			end else begin
				best_val_q <= best_val_d;
				best_pos_q <= best_pos_d;
				run_val_q  <= run_val_d;
				run_pos_q  <= run_pos_d;
				if (count_q != CNT_MAX) begin
					count_q <= count_q + 1'b1;
				end
			end
		end
	end

endmodule

/* hdl/ttd_resq.sv */
module ttd_resq import ttd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  push_t push,
	input  logic  pop,
	output logic  room,
	output logic  nonempty,
	output res_t  head
);

	res_t                mem [RQ_DEPTH];
	logic [RQ_PTR_W-1:0] wr_q;
	logic [RQ_PTR_W-1:0] rd_q;
	logic [RQ_CNT_W-1:0] cnt_q;
	logic [RQ_PTR_W-1:0] wr_next;

	assign wr_next  = wr_q + 1'b1;
	// two free entries cover the worst item
	assign room     = cnt_q <= RQ_CNT_W'(RQ_DEPTH - 2);
	assign nonempty = cnt_q != '0;
	assign head     = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem[wr_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			mem[wr_next] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + RQ_PTR_W'(push.count);
			cnt_q <= cnt_q + RQ_CNT_W'(push.count) - RQ_CNT_W'(pop);
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
		end
	end

endmodule

/* hdl/threshold_and_top_two_detect.sv */
// channel   | direction | beat contents
// ----------+-----------+-------------------------------------------
// samples   | in        | value, end_of_sequence
// results   | out       | position, has_position, list_end
// apb       | in/out    | threshold (0x0), top_two_mode (0x4)
//
// one sample beat per cycle while the result queue has room; a result passes the input register, then the result queue
// a top-two end-of-sequence sample yields two result beats, drained one per cycle while results.ready is high
// the result queue holds four beats; the input stage stalls when fewer than two are free
// reset clears the sequence state, the registers and the queue at once; no clearing pass
module threshold_and_top_two_detect import ttd_pkg::*; #(
	parameter int MAX_LEN    = DEF_MAX_LEN,
	parameter int VALUE_BITS = DEF_VALUE_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	ttd_sample_if.sink            samples,
	ttd_result_if.source          results,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	// usable value width: bits above it are ignored everywhere
	localparam int VAL_W = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;

	// configuration registers
	logic [VAL_W-1:0] threshold_q;
	logic             mode_q;
	logic             reg_idx;
	logic             cfg_wr;

	// input stage
	logic               smp_valid_s1;
	logic [VALUE_W-1:0] smp_value_s1;
	logic               smp_eos_s1;
	logic               fire;

	// result path
	push_t push;
	logic  room;
	logic  nonempty;
	res_t  head;
	logic  pop;

	// ---------------- apb register file ----------------
	assign pready  = 1'b1;
	assign reg_idx = paddr[2];
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= '0;
			mode_q      <= 1'b0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_THRESHOLD: threshold_q <= pwdata[VAL_W-1:0];
				REG_MODE:      mode_q      <= pwdata[0];
				default:       ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_THRESHOLD: prdata = APB_DATA_W'(threshold_q);
			REG_MODE:      prdata = APB_DATA_W'(mode_q);
			default:       prdata = '0;
		endcase
	end

	// ---------------- input register ----------------
	// the sample moves on once the queue can take every result it may make
	assign fire          = smp_valid_s1 && room;
	assign samples.ready = !smp_valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smp_valid_s1 <= 1'b0;
		end else if (samples.ready) begin
			smp_valid_s1 <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (samples.ready && samples.valid) begin
			smp_value_s1 <= samples.value;
			smp_eos_s1   <= samples.end_of_sequence;
		end
	end

	// ---------------- compare and track ----------------
	ttd_track #(
		.MAX_LEN    (MAX_LEN),
		.VALUE_BITS (VALUE_BITS)
	) u_track (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.value     (smp_value_s1),
		.eos       (smp_eos_s1),
		.threshold (threshold_q),
		.mode      (mode_q),
		.push      (push)
	);

	// ---------------- result queue ----------------
	// doubles as the output register; a stalled result blocks intake once fewer than two entries are free
	ttd_resq u_resq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.pop      (pop),
		.room     (room),
		.nonempty (nonempty),
		.head     (head)
	);

	assign pop                  = nonempty && results.ready;
	assign results.valid        = nonempty;
	assign results.position     = head.position;
	assign results.has_position = head.has_position;
	assign results.list_end     = head.list_end;

endmodule
